// ===== src/fds_pkg.sv =====
// fds_pkg: shared types, constants and helpers of the frame difference scene cut block
// no dependencies; imported by fds_front, fds_back and frame_difference_scene_cut
`default_nettype none

package fds_pkg;

  // default sizing
  localparam int unsigned DEF_MAX_PIXELS       = 2097152;
  localparam int unsigned DEF_FRAME_INDEX_BITS = 24;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned FP_W   = 22;
  localparam int unsigned SUM_W  = 29;
  localparam int unsigned CFG_W  = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [SUM_W-1:0] SUM_LIMIT = {SUM_W{1'b1}};

  // register reset values
  localparam logic             MODE_RST         = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 16'd7680;
  localparam logic [FP_W-1:0]  FRAME_PIXELS_RST = 22'd307200;

  // queue depths
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;

  // grey weights, q14
  localparam int unsigned GREY_B     = 1868;
  localparam int unsigned GREY_G     = 9617;
  localparam int unsigned GREY_R     = 4899;
  localparam int unsigned GREY_ROUND = 8192;
  localparam int unsigned GREY_PROD_W = 22;
  localparam int unsigned GREY_SUM_W  = 23;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 2'd0,
    CFG_THRESHOLD    = 2'd1,
    CFG_FRAME_PIXELS = 2'd2
  } cfg_idx_t;

  // frame phase, also the kind of work an item gets
  typedef enum logic [2:0] {
    PH_BG  = 3'b001,
    PH_REF = 3'b010,
    PH_CMP = 3'b100
  } phase_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  // classification handed from front to back
  typedef struct packed {
    phase_t kind;
    logic   mode;
    logic   first;
    logic   emit;
    logic   suppress;
  } op_ctl_t;

  function automatic logic [PIX_W-1:0] absdiff8(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== src/fds_fifo.sv =====
// fds_fifo: small register-based first-in first-out queue
// no package dependencies; used for the front-to-back queue and the result queue
`default_nettype none

module fds_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  full,
  output logic                  empty,
  output logic      [CNT_W-1:0] count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== src/fds_front.sv =====
// fds_front: accepts pixels, tracks position, setup phase and frame count, classifies each item
// depends on fds_pkg; feeds the front-to-back queue
`default_nettype none

module fds_front #(
  parameter int unsigned MAX_PIXELS       = fds_pkg::DEF_MAX_PIXELS,
  parameter int unsigned FRAME_INDEX_BITS = fds_pkg::DEF_FRAME_INDEX_BITS,
  localparam int unsigned ADDR_W = $clog2(MAX_PIXELS),
  localparam int unsigned N_W    = $clog2(MAX_PIXELS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_push,
  input  wire fds_pkg::pix_t               in_pix,
  input  wire logic                        in_new_video,
  input  wire logic                        cfg_mode,
  input  wire logic [N_W-1:0]              frame_n,
  input  wire logic                        q_full,
  output logic                             q_push,
  output fds_pkg::op_ctl_t                 q_ctl,
  output fds_pkg::pix_t                    q_pix,
  output logic [ADDR_W-1:0]                q_addr,
  output logic [FRAME_INDEX_BITS-1:0]      q_idx
);

  import fds_pkg::*;

  logic [ADDR_W-1:0]           pos_r, pos_nxt, pos_cur;
  phase_t                      phase_r, phase_nxt, phase_cur;
  logic [FRAME_INDEX_BITS-1:0] count_r, count_nxt, count_cur;
  logic                        last;
  logic                        emit;

  assign q_push = in_push && !q_full;

  // new video restarts the counters before the pixel is used
  always_comb begin
    pos_cur   = in_new_video ? '0 : pos_r;
    phase_cur = in_new_video ? PH_BG : phase_r;
    count_cur = in_new_video ? '0 : count_r;
    last      = ((N_W'(pos_cur) + N_W'(1)) >= frame_n);
    emit      = (phase_cur == PH_CMP) && last;
  end

  // item classification
  always_comb begin
    q_ctl.kind     = phase_cur;
    q_ctl.mode     = cfg_mode;
    q_ctl.first    = (pos_cur == '0);
    q_ctl.emit     = emit;
    q_ctl.suppress = cfg_mode && (count_cur == '0);
    q_pix          = in_pix;
    q_addr         = pos_cur;
    q_idx          = count_cur;
  end

  // position, phase and frame count advance
  always_comb begin
    pos_nxt   = last ? '0 : pos_cur + ADDR_W'(1);
    count_nxt = emit ? count_cur + FRAME_INDEX_BITS'(1) : count_cur;
    phase_nxt = phase_cur;
    if (last) begin
      unique case (phase_cur)
        PH_BG:   phase_nxt = cfg_mode ? PH_REF : PH_CMP;
        PH_REF:  phase_nxt = PH_CMP;
        PH_CMP:  phase_nxt = PH_CMP;
        default: phase_nxt = PH_BG;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_BG;
      count_r <= '0;
    end else if (q_push) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/fds_back.sv =====
// fds_back: frame memories, difference pipeline, accumulator and cut decision
// depends on fds_pkg; pops the front-to-back queue and pushes the result queue
`default_nettype none

module fds_back #(
  parameter int unsigned MAX_PIXELS       = fds_pkg::DEF_MAX_PIXELS,
  parameter int unsigned FRAME_INDEX_BITS = fds_pkg::DEF_FRAME_INDEX_BITS,
  parameter int unsigned RES_DEPTH        = fds_pkg::OUT_DEPTH,
  localparam int unsigned ADDR_W = $clog2(MAX_PIXELS),
  localparam int unsigned N_W    = $clog2(MAX_PIXELS + 1),
  localparam int unsigned CNT_W  = $clog2(RES_DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_empty,
  input  wire fds_pkg::op_ctl_t             q_ctl,
  input  wire fds_pkg::pix_t                q_pix,
  input  wire logic [ADDR_W-1:0]            q_addr,
  input  wire logic [FRAME_INDEX_BITS-1:0]  q_idx,
  output logic                              q_pop,
  input  wire logic [fds_pkg::THR_W-1:0]    cfg_thr,
  input  wire logic [N_W-1:0]               frame_n,
  input  wire logic [CNT_W-1:0]             res_count,
  output logic                              res_push,
  output logic [FRAME_INDEX_BITS-1:0]       res_idx,
  output logic                              res_cut,
  output logic [fds_pkg::SUM_W-1:0]         res_sum
);

  import fds_pkg::*;

  localparam int unsigned PROD_W = THR_W + N_W;
  localparam int unsigned CUT_W  = (PROD_W > SUM_W + 8) ? PROD_W : SUM_W + 8;

  // frame memories
  logic [PIX_W-1:0]   prev_mem [MAX_PIXELS];
  logic [3*PIX_W-1:0] bg_mem   [MAX_PIXELS];

  // stage 1: item with read data
  logic                        s1_v_r;
  op_ctl_t                     s1_ctl_r;
  pix_t                        s1_pix_r;
  logic [ADDR_W-1:0]           s1_addr_r;
  logic [FRAME_INDEX_BITS-1:0] s1_idx_r;
  logic [PIX_W-1:0]            prev_rd_r;
  pix_t                        bg_rd_r;

  // stage 2: grey products
  logic                        s2_v_r;
  op_ctl_t                     s2_ctl_r;
  logic [ADDR_W-1:0]           s2_addr_r;
  logic [FRAME_INDEX_BITS-1:0] s2_idx_r;
  logic [PIX_W-1:0]            s2_blue_r;
  logic [PIX_W-1:0]            s2_prev_r;
  logic [GREY_PROD_W-1:0]      s2_pb_r, s2_pg_r, s2_pr_r;

  // stage 3: finished frame sum
  logic                        s3_v_r;
  logic [FRAME_INDEX_BITS-1:0] s3_idx_r;
  logic [SUM_W-1:0]            s3_sum_r;
  logic                        s3_sup_r;

  // recent previous-frame writes for forwarding
  logic                        w1_v_r, w2_v_r;
  logic [ADDR_W-1:0]           w1_addr_r, w2_addr_r;
  logic [PIX_W-1:0]            w1_data_r, w2_data_r;

  logic [SUM_W-1:0]            acc_r, acc_nxt;
  logic [PROD_W-1:0]           thr_n_r;

  logic [CNT_W+1:0]            credit_used;
  pix_t                        opnd;
  logic [GREY_SUM_W-1:0]       grey_sum;
  logic [PIX_W-1:0]            grey, cur, prev_eff, diff;
  logic [SUM_W:0]              acc_add;
  logic [SUM_W-1:0]            acc_base;
  logic                        is_cmp;

  // pop only with room in the result queue for every frame end in flight
  always_comb begin
    credit_used = (CNT_W+2)'(res_count)
                + (CNT_W+2)'(s1_v_r && s1_ctl_r.emit)
                + (CNT_W+2)'(s2_v_r && s2_ctl_r.emit)
                + (CNT_W+2)'(s3_v_r);
    q_pop = !q_empty && (credit_used < (CNT_W+2)'(RES_DEPTH));
  end

  // previous frame memory: read at pop, written at the end of the pipeline
  always_ff @(posedge clk) begin
    if (q_pop) begin
      prev_rd_r <= prev_mem[q_addr];
    end
    if (s2_v_r) begin
      prev_mem[s2_addr_r] <= cur;
    end
  end

  // background memory: stored from the first frame at pop
  always_ff @(posedge clk) begin
    if (q_pop) begin
      bg_rd_r <= bg_mem[q_addr];
    end
    if (q_pop && (q_ctl.kind == PH_BG)) begin
      bg_mem[q_addr] <= q_pix;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_ctl_r  <= q_ctl;
      s1_pix_r  <= q_pix;
      s1_addr_r <= q_addr;
      s1_idx_r  <= q_idx;
    end
  end

  // grey operands: raw pixel for the reference frame, else distance to background
  always_comb begin
    if (s1_ctl_r.kind == PH_REF) begin
      opnd = s1_pix_r;
    end else begin
      opnd.blue  = absdiff8(s1_pix_r.blue,  bg_rd_r.blue);
      opnd.green = absdiff8(s1_pix_r.green, bg_rd_r.green);
      opnd.red   = absdiff8(s1_pix_r.red,   bg_rd_r.red);
    end
  end

  always_ff @(posedge clk) begin
    s2_ctl_r  <= s1_ctl_r;
    s2_addr_r <= s1_addr_r;
    s2_idx_r  <= s1_idx_r;
    s2_blue_r <= s1_pix_r.blue;
    s2_prev_r <= prev_rd_r;
    s2_pb_r   <= GREY_PROD_W'(opnd.blue)  * GREY_PROD_W'(GREY_B);
    s2_pg_r   <= GREY_PROD_W'(opnd.green) * GREY_PROD_W'(GREY_G);
    s2_pr_r   <= GREY_PROD_W'(opnd.red)   * GREY_PROD_W'(GREY_R);
  end

  // grey, current value, forwarded previous value and accumulate
  always_comb begin
    grey_sum = GREY_SUM_W'(s2_pb_r) + GREY_SUM_W'(s2_pg_r) + GREY_SUM_W'(s2_pr_r)
             + GREY_SUM_W'(GREY_ROUND);
    grey     = grey_sum[21:14];
    is_cmp   = (s2_ctl_r.kind == PH_CMP);
    priority case (1'b1)
      (s2_ctl_r.kind == PH_BG):  cur = s2_blue_r;
      (s2_ctl_r.kind == PH_REF): cur = grey;
      default:                   cur = s2_ctl_r.mode ? grey : s2_blue_r;
    endcase
    priority if (w1_v_r && (w1_addr_r == s2_addr_r)) begin
      prev_eff = w1_data_r;
    end else if (w2_v_r && (w2_addr_r == s2_addr_r)) begin
      prev_eff = w2_data_r;
    end else begin
      prev_eff = s2_prev_r;
    end
    diff     = absdiff8(cur, prev_eff);
    acc_base = s2_ctl_r.first ? '0 : acc_r;
    acc_add  = (SUM_W+1)'(acc_base) + (SUM_W+1)'(diff);
    acc_nxt  = acc_add[SUM_W] ? SUM_LIMIT : acc_add[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    w1_addr_r <= s2_addr_r;
    w1_data_r <= cur;
    w2_addr_r <= w1_addr_r;
    w2_data_r <= w1_data_r;
    s3_idx_r  <= s2_idx_r;
    s3_sum_r  <= acc_nxt;
    s3_sup_r  <= s2_ctl_r.suppress;
    thr_n_r   <= PROD_W'(cfg_thr) * PROD_W'(frame_n);
  end

  // pipeline valids and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      w1_v_r <= 1'b0;
      w2_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r <= q_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_ctl_r.emit;
      w1_v_r <= s2_v_r;
      w2_v_r <= w1_v_r;
      if (s2_v_r && is_cmp) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // cut test: sum * 256 > threshold * pixel count, unless suppressed
  always_comb begin
    res_push = s3_v_r;
    res_idx  = s3_idx_r;
    res_sum  = s3_sum_r;
    res_cut  = (CUT_W'({s3_sum_r, 8'b0}) > CUT_W'(thr_n_r)) && !s3_sup_r;
  end

`ifndef SYNTHESIS
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (res_count < CNT_W'(RES_DEPTH)))
    else $error("result pushed into a full result queue");

  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> s2_v_r)
    else $error("pipeline item lost between stages");

  a_emit_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && s2_ctl_r.emit) |-> (s2_ctl_r.kind == PH_CMP))
    else $error("frame end result from a setup frame");
`endif

endmodule

`default_nettype wire

// ===== src/frame_difference_scene_cut.sv =====
// frame_difference_scene_cut: one result (frame index, cut flag, sum) at each compared frame end
// rate: one pixel per cycle sustained; a result follows its frame's last accepted pixel through
// front queue, memory read, grey products, accumulate, cut test
// pixels stall only while the result queue has no room for frame ends in flight
// reset (rst_n low, synchronous) clears counters, phase, queues and config to defaults;
// frame memories are not cleared and hold no data until the first frame is stored
`default_nettype none

module frame_difference_scene_cut #(
  parameter int unsigned MAX_PIXELS       = fds_pkg::DEF_MAX_PIXELS,
  parameter int unsigned FRAME_INDEX_BITS = fds_pkg::DEF_FRAME_INDEX_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_push,
  output logic                                   in_full,
  input  wire logic [fds_pkg::PIX_W-1:0]         in_blue,
  input  wire logic [fds_pkg::PIX_W-1:0]         in_green,
  input  wire logic [fds_pkg::PIX_W-1:0]         in_red,
  input  wire logic                              in_new_video,
  output logic                                   out_empty,
  input  wire logic                              out_pop,
  output logic [FRAME_INDEX_BITS-1:0]            out_frame_index,
  output logic                                   out_scene_cut,
  output logic [fds_pkg::SUM_W-1:0]              out_difference_sum,
  input  wire logic                              cfg_we,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fds_pkg::CFG_W-1:0]         cfg_data
);

  import fds_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_PIXELS);
  localparam int unsigned N_W    = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CMP_W  = (N_W > FP_W) ? N_W : FP_W;
  localparam int unsigned MID_W  = $bits(op_ctl_t) + $bits(pix_t) + ADDR_W + FRAME_INDEX_BITS;
  localparam int unsigned RES_W  = FRAME_INDEX_BITS + 1 + SUM_W;
  localparam int unsigned RES_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

  logic             mode_r;
  logic [THR_W-1:0] thr_r;
  logic [FP_W-1:0]  fp_r;
  logic [N_W-1:0]   frame_n;

  pix_t                        in_pix;
  logic                        f_push;
  op_ctl_t                     f_ctl;
  pix_t                        f_pix;
  logic [ADDR_W-1:0]           f_addr;
  logic [FRAME_INDEX_BITS-1:0] f_idx;

  logic                        mq_full, mq_empty, mq_pop;
  logic [MID_W-1:0]            mq_data;
  logic [MID_CNT_W-1:0]        mq_count;
  op_ctl_t                     mq_ctl;
  pix_t                        mq_pix;
  logic [ADDR_W-1:0]           mq_addr;
  logic [FRAME_INDEX_BITS-1:0] mq_idx;

  logic                        res_push, res_cut, res_full;
  logic [FRAME_INDEX_BITS-1:0] res_idx;
  logic [SUM_W-1:0]            res_sum;
  logic [RES_CNT_W-1:0]        res_count;
  logic [RES_W-1:0]            res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      thr_r  <= THRESHOLD_RST;
      fp_r   <= FRAME_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:         mode_r <= cfg_data[0];
        CFG_THRESHOLD:    thr_r  <= cfg_data[THR_W-1:0];
        CFG_FRAME_PIXELS: fp_r   <= cfg_data[FP_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to one through the memory depth
  always_comb begin
    if (fp_r == '0) begin
      frame_n = N_W'(1);
    end else if (CMP_W'(fp_r) > CMP_W'(MAX_PIXELS)) begin
      frame_n = N_W'(MAX_PIXELS);
    end else begin
      frame_n = N_W'(fp_r);
    end
  end

  assign in_pix.blue  = in_blue;
  assign in_pix.green = in_green;
  assign in_pix.red   = in_red;
  assign in_full      = mq_full;

  fds_front #(
    .MAX_PIXELS      (MAX_PIXELS),
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_pix      (in_pix),
    .in_new_video(in_new_video),
    .cfg_mode    (mode_r),
    .frame_n     (frame_n),
    .q_full      (mq_full),
    .q_push      (f_push),
    .q_ctl       (f_ctl),
    .q_pix       (f_pix),
    .q_addr      (f_addr),
    .q_idx       (f_idx)
  );

  // queue between front and back
  fds_fifo #(
    .WIDTH(MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .push_data({f_ctl, f_pix, f_addr, f_idx}),
    .pop      (mq_pop),
    .pop_data (mq_data),
    .full     (mq_full),
    .empty    (mq_empty),
    .count    (mq_count)
  );

  assign {mq_ctl, mq_pix, mq_addr, mq_idx} = mq_data;

  fds_back #(
    .MAX_PIXELS      (MAX_PIXELS),
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS),
    .RES_DEPTH       (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (mq_empty),
    .q_ctl    (mq_ctl),
    .q_pix    (mq_pix),
    .q_addr   (mq_addr),
    .q_idx    (mq_idx),
    .q_pop    (mq_pop),
    .cfg_thr  (thr_r),
    .frame_n  (frame_n),
    .res_count(res_count),
    .res_push (res_push),
    .res_idx  (res_idx),
    .res_cut  (res_cut),
    .res_sum  (res_sum)
  );

  // result queue
  fds_fifo #(
    .WIDTH(RES_W),
    .DEPTH(OUT_DEPTH)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data({res_idx, res_cut, res_sum}),
    .pop      (out_pop),
    .pop_data (res_data),
    .full     (res_full),
    .empty    (out_empty),
    .count    (res_count)
  );

  assign {out_frame_index, out_scene_cut, out_difference_sum} = res_data;

`ifndef SYNTHESIS
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result queue overflow");

  a_mid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mq_count <= MID_CNT_W'(MID_DEPTH))
    else $error("front-to-back queue count beyond its depth");
`endif

endmodule

`default_nettype wire
